// ===== rtl/dfgsh_pkg.sv =====
package dfgsh_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned DigitW  = 8;
  localparam int unsigned NumDig  = WordW / DigitW;
  localparam int unsigned DigIdxW = $clog2(NumDig);

  localparam logic [WordW-1:0] FnvPrime    = 64'd1099511628211;
  localparam logic [WordW-1:0] GoldenMul   = 64'h9E3779B97F4A7C15;
  localparam int unsigned      GoldenShift = 29;
  localparam logic [WordW-1:0] FnvBasis    = 64'd1469598103934665603;

  localparam logic [3:0] FullCount = 4'd8;

  function automatic logic [DigitW-1:0] fnv_digit(input logic [DigIdxW-1:0] idx);
    logic [WordW-1:0] sh;
    sh = FnvPrime >> {idx, 3'b000};
    return sh[DigitW-1:0];
  endfunction

  function automatic logic [DigitW-1:0] golden_digit(input logic [DigIdxW-1:0] idx);
    logic [WordW-1:0] sh;
    sh = GoldenMul >> {idx, 3'b000};
    return sh[DigitW-1:0];
  endfunction

endpackage

// ===== rtl/dual_fnv_golden_stream_hash.sv =====
// Channel  Direction  Ports                                        Beat
// in_      input      in_word_data[63:0] in_valid_bytes[3:0] in_last  in_valid & in_ready
// out_     output     out_hash_low[63:0] out_hash_high[63:0]       out_valid & out_ready
//
// One item at a time. An 8-byte word is mixed as one unit, a tail of n bytes as n single
// bytes, and a count of zero mixes nothing. A last item then passes the finalize state,
// which registers the fingerprint. Each mix is two 64x64 multiplies done one 8-bit
// constant digit per cycle after the load state. The output register lets the next item
// start while a fingerprint waits; a second stays in the finalize state until out_ready frees it.
// rst_n is synchronous: accumulators go to their start values and out_valid drops.
module dual_fnv_golden_stream_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_word_data,
  input  logic [3:0]  in_valid_bytes,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_hash_low,
  output logic [63:0] out_hash_high
);

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_MUL, S_FIN} state_t;

  state_t                        state_r, state_nxt;
  logic [dfgsh_pkg::WordW-1:0]   fnv_r, fnv_nxt;
  logic [dfgsh_pkg::WordW-1:0]   gold_r, gold_nxt;
  logic [dfgsh_pkg::WordW-1:0]   total_r, total_nxt;
  logic [dfgsh_pkg::WordW-1:0]   word_r, word_nxt;
  logic [dfgsh_pkg::WordW-1:0]   mcf_r, mcf_nxt;
  logic [dfgsh_pkg::WordW-1:0]   mcg_r, mcg_nxt;
  logic [dfgsh_pkg::WordW-1:0]   pf_r, pf_nxt;
  logic [dfgsh_pkg::WordW-1:0]   pg_r, pg_nxt;
  logic [dfgsh_pkg::DigIdxW-1:0] dig_r, dig_nxt;
  logic [2:0]                    rem_r, rem_nxt;
  logic                          full_r, full_nxt;
  logic                          last_r, last_nxt;
  logic                          ov_r, ov_nxt;
  logic [dfgsh_pkg::WordW-1:0]   olo_r, olo_nxt;
  logic [dfgsh_pkg::WordW-1:0]   ohi_r, ohi_nxt;

  logic [3:0]                    cnt;
  logic [dfgsh_pkg::WordW-1:0]   unit;
  logic [dfgsh_pkg::WordW-1:0]   pf_sum, pg_sum;

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = ov_r;
  assign out_hash_low  = olo_r;
  assign out_hash_high = ohi_r;

  always_comb begin
    cnt    = (in_valid_bytes > dfgsh_pkg::FullCount) ? dfgsh_pkg::FullCount : in_valid_bytes;
    unit   = full_r ? word_r : {56'd0, word_r[7:0]};
    pf_sum = pf_r + 64'(mcf_r * {56'd0, dfgsh_pkg::fnv_digit(dig_r)});
    pg_sum = pg_r + 64'(mcg_r * {56'd0, dfgsh_pkg::golden_digit(dig_r)});

    state_nxt = state_r;
    fnv_nxt   = fnv_r;
    gold_nxt  = gold_r;
    total_nxt = total_r;
    word_nxt  = word_r;
    mcf_nxt   = mcf_r;
    mcg_nxt   = mcg_r;
    pf_nxt    = pf_r;
    pg_nxt    = pg_r;
    dig_nxt   = dig_r;
    rem_nxt   = rem_r;
    full_nxt  = full_r;
    last_nxt  = last_r;
    ov_nxt    = ov_r & ~out_ready;
    olo_nxt   = olo_r;
    ohi_nxt   = ohi_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          total_nxt = total_r + {60'd0, cnt};
          word_nxt  = in_word_data;
          full_nxt  = cnt[3];
          rem_nxt   = cnt[3] ? 3'd1 : cnt[2:0];
          last_nxt  = in_last;
          if (cnt != 4'd0) begin
            state_nxt = S_LOAD;
          end else if (in_last) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_LOAD: begin
        mcf_nxt   = fnv_r ^ unit;
        mcg_nxt   = gold_r + unit;
        pf_nxt    = '0;
        pg_nxt    = '0;
        dig_nxt   = '0;
        word_nxt  = word_r >> dfgsh_pkg::DigitW;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        pf_nxt  = pf_sum;
        pg_nxt  = pg_sum;
        mcf_nxt = mcf_r << dfgsh_pkg::DigitW;
        mcg_nxt = mcg_r << dfgsh_pkg::DigitW;
        dig_nxt = dig_r + 1'b1;
        if (dig_r == dfgsh_pkg::DigIdxW'(dfgsh_pkg::NumDig - 1)) begin
          fnv_nxt  = pf_sum;
          gold_nxt = pg_sum ^ (pg_sum >> dfgsh_pkg::GoldenShift);
          rem_nxt  = rem_r - 1'b1;
          if (rem_r != 3'd1) begin
            state_nxt = S_LOAD;
          end else if (last_r) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FIN: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          olo_nxt   = fnv_r;
          ohi_nxt   = gold_r ^ total_r;
          fnv_nxt   = dfgsh_pkg::FnvBasis;
          gold_nxt  = '0;
          total_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      fnv_r   <= dfgsh_pkg::FnvBasis;
      gold_r  <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      fnv_r   <= fnv_nxt;
      gold_r  <= gold_nxt;
      total_r <= total_nxt;
    end
    word_r <= word_nxt;
    mcf_r  <= mcf_nxt;
    mcg_r  <= mcg_nxt;
    pf_r   <= pf_nxt;
    pg_r   <= pg_nxt;
    dig_r  <= dig_nxt;
    rem_r  <= rem_nxt;
    full_r <= full_nxt;
    last_r <= last_nxt;
    olo_r  <= olo_nxt;
    ohi_r  <= ohi_nxt;
  end

endmodule

// ===== dv/fingerprint_checker.sv =====
module fingerprint_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [dfgsh_pkg::WordW-1:0] in_word_data,
  input  logic [3:0]                  in_valid_bytes,
  input  logic                        in_last,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [dfgsh_pkg::WordW-1:0] out_hash_low,
  input  logic [dfgsh_pkg::WordW-1:0] out_hash_high,
  output int                          mismatches,
  output int                          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [dfgsh_pkg::WordW-1:0] low;
    logic [dfgsh_pkg::WordW-1:0] high;
  } fingerprint_t;

  fingerprint_t                fingerprint_q[$];
  logic [dfgsh_pkg::WordW-1:0] fnv_acc;
  logic [dfgsh_pkg::WordW-1:0] golden_acc;
  logic [dfgsh_pkg::WordW-1:0] byte_count;

  function automatic void restart_hash();
    fnv_acc    = dfgsh_pkg::FnvBasis;
    golden_acc = '0;
    byte_count = '0;
  endfunction

  function automatic void absorb_unit(input logic [dfgsh_pkg::WordW-1:0] d);
    fnv_acc    = (fnv_acc ^ d) * dfgsh_pkg::FnvPrime;
    golden_acc = (golden_acc + d) * dfgsh_pkg::GoldenMul;
    golden_acc = golden_acc ^ (golden_acc >> dfgsh_pkg::GoldenShift);
  endfunction

  function automatic void hash_beat(input logic [dfgsh_pkg::WordW-1:0] word,
                                    input logic [3:0] vb,
                                    input logic last);
    logic [3:0]   n;
    fingerprint_t fp;
    n = (vb > dfgsh_pkg::FullCount) ? dfgsh_pkg::FullCount : vb;
    if (n == dfgsh_pkg::FullCount) begin
      absorb_unit(word);
    end else begin
      for (int k = 0; k < n; k++) begin
        absorb_unit({{(dfgsh_pkg::WordW-dfgsh_pkg::DigitW){1'b0}},
                     word[dfgsh_pkg::DigitW*k +: dfgsh_pkg::DigitW]});
      end
    end
    byte_count = byte_count + dfgsh_pkg::WordW'(n);
    if (last) begin
      fp.low  = fnv_acc;
      fp.high = golden_acc ^ byte_count;
      fingerprint_q = {fingerprint_q, fp};
      restart_hash();
    end
  endfunction

  always @(posedge clk) begin : monitor
    fingerprint_t exp_fp;
    if (!rst_n) begin
      restart_hash();
      fingerprint_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        hash_beat(in_word_data, in_valid_bytes, in_last);
      end
      if (out_valid && out_ready) begin
        if (fingerprint_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected fingerprint low %h high %h", $realtime, out_hash_low,
                     out_hash_high);
          end
        end else begin
          exp_fp = fingerprint_q.pop_front();
          if (exp_fp.low !== out_hash_low || exp_fp.high !== out_hash_high) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: fingerprint mismatch: low exp %h got %h, high exp %h got %h",
                       $realtime, exp_fp.low, out_hash_low, exp_fp.high, out_hash_high);
            end
          end
        end
      end
    end
    outstanding = fingerprint_q.size();
  end

endmodule

// ===== dv/tb_dual_fnv_golden_stream_hash.sv =====
module tb_dual_fnv_golden_stream_hash;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 1_200_000;
  localparam int unsigned RandomItems = 1830;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 100;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [dfgsh_pkg::WordW-1:0] in_word_data;
  logic [3:0]                  in_valid_bytes;
  logic                        in_last;
  logic                        out_valid;
  logic                        out_ready;
  logic [dfgsh_pkg::WordW-1:0] out_hash_low;
  logic [dfgsh_pkg::WordW-1:0] out_hash_high;
  int                          mismatches;
  int                          outstanding;

  int unsigned beats_sent;
  int unsigned cycle_count = 0;
  bit          tx_steady;
  bit          rx_steady;
  bit          hold_req;

  dual_fnv_golden_stream_hash u_top (.*);

  fingerprint_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [dfgsh_pkg::WordW-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [3:0] rand_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return dfgsh_pkg::FullCount;
    if (r < 85) return 4'($urandom_range(1, 7));
    if (r < 92) return 4'd0;
    return 4'($urandom_range(9, 15));
  endfunction

  function automatic int unsigned msg_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return 1;
    if (r < 75) return $urandom_range(2, 6);
    if (r < 95) return $urandom_range(7, 20);
    return $urandom_range(21, 60);
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_beat(input logic [dfgsh_pkg::WordW-1:0] w, input logic [3:0] vb,
                           input logic l);
    int unsigned n;
    in_valid       <= 1'b1;
    in_word_data   <= w;
    in_valid_bytes <= vb;
    in_last        <= l;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    @(negedge clk);
    n = tx_steady ? 0 : gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_beat(rand_word(), rand_count(), i == len - 1);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk);
  endtask

  initial begin : receiver
    int unsigned idle_left;
    idle_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_left > 0) begin
        out_ready <= 1'b0;
        idle_left--;
      end else begin
        out_ready <= 1'b1;
        if (!rx_steady) idle_left = gap_len();
      end
    end
  end

  initial begin : stimulus
    int unsigned rand_start;
    int unsigned phase;
    in_valid       = 1'b0;
    in_word_data   = '0;
    in_valid_bytes = '0;
    in_last        = 1'b0;
    rst_n          = 1'b0;
    tx_steady      = 1'b0;
    rx_steady      = 1'b0;
    hold_req       = 1'b0;
    beats_sent     = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_beat('0, dfgsh_pkg::FullCount, 1'b1);
    send_beat('1, dfgsh_pkg::FullCount, 1'b1);
    send_beat(rand_word(), 4'd0, 1'b1);
    // bytes above the count must be ignored
    send_beat(64'hFFFF_FFFF_FFFF_FF5A, 4'd1, 1'b1);
    for (int n = 1; n < 8; n++) begin
      send_beat((n % 2) ? '1 : {$urandom, $urandom}, 4'(n), 1'b1);
    end
    send_beat(rand_word(), 4'd9, 1'b1);
    send_beat('1, 4'd15, 1'b1);
    send_beat(rand_word(), dfgsh_pkg::FullCount, 1'b0);
    send_beat(rand_word(), 4'd3, 1'b0);
    send_beat(rand_word(), 4'd0, 1'b0);
    send_beat(rand_word(), 4'd12, 1'b0);
    send_beat(rand_word(), 4'd5, 1'b1);
    send_beat(rand_word(), 4'd0, 1'b0);
    send_beat(rand_word(), 4'd0, 1'b1);
    drain_results();

    rand_start = beats_sent;
    phase = 0;
    while (beats_sent - rand_start < RandomItems) begin
      tx_steady = (phase % 4 == 1);
      rx_steady = (phase % 4 == 2);
      if (phase == 3) begin
        // receiver stalls long while single-beat fingerprints keep coming
        hold_req = 1'b1;
        repeat (12) send_beat(rand_word(), dfgsh_pkg::FullCount, 1'b1);
      end
      if (phase == 5) drain_results();
      repeat (8) send_message(msg_len());
      phase++;
    end

    in_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
